FILE: sv/iptc_pkg.sv
// ----------------------------------------------------------------------------
// iptc_pkg
// shared types, constants and lookup functions for the infix to postfix core
// ----------------------------------------------------------------------------
package iptc_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CODE_W      = 3;

  // ascii codes of interest
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [CODE_W-1:0] {
    OP_LPAR  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_POW   = 3'd5
  } op_code_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_END,
    K_OPERAND,
    K_OPEN,
    K_CLOSE,
    K_OPER
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_DRAIN
  } back_state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last_of_run;
    status_e    status;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    op_code_e   code;
  } op_t;

  function automatic logic [7:0] code_to_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      OP_LPAR:  c = CH_LPAR;
      OP_PLUS:  c = CH_PLUS;
      OP_MINUS: c = CH_MINUS;
      OP_MUL:   c = CH_STAR;
      OP_DIV:   c = CH_SLASH;
      OP_POW:   c = CH_CARET;
      default:  c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_to_prec(input logic [CODE_W-1:0] code);
    logic [1:0] p;
    case (code)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      OP_POW:            p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/iptc_ram.sv
// ----------------------------------------------------------------------------
// iptc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module iptc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/iptc_front.sv
// ----------------------------------------------------------------------------
// iptc_front
// takes input characters, classifies them and drops those with no effect
// ----------------------------------------------------------------------------
module iptc_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  iptc_pkg::in_item_t in_item_i,
  output logic              q_push_o,
  output iptc_pkg::op_t     q_data_o,
  input  logic              q_full_i
);
  import iptc_pkg::*;

  logic [7:0] c;
  logic       is_alnum;
  logic       keep;

  assign c = in_item_i.char_code;
  assign is_alnum = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                    ((c >= 8'h30) && (c <= 8'h39));

  always_comb begin
    keep          = 1'b1;
    q_data_o.ch   = c;
    q_data_o.code = OP_LPAR;
    q_data_o.kind = K_OPER;
    if (in_item_i.command) begin
      q_data_o.kind = K_END;
    end else if (is_alnum) begin
      q_data_o.kind = K_OPERAND;
    end else begin
      case (c)
        CH_LPAR:  q_data_o.kind = K_OPEN;
        CH_RPAR:  q_data_o.kind = K_CLOSE;
        CH_PLUS:  q_data_o.code = OP_PLUS;
        CH_MINUS: q_data_o.code = OP_MINUS;
        CH_STAR:  q_data_o.code = OP_MUL;
        CH_SLASH: q_data_o.code = OP_DIV;
        CH_CARET: q_data_o.code = OP_POW;
        default:  keep = 1'b0;
      endcase
    end
  end

  // ignored characters are taken and dropped here
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && keep && !q_full_i;

endmodule

FILE: sv/iptc_queue.sv
// ----------------------------------------------------------------------------
// iptc_queue
// two entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module iptc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  iptc_pkg::op_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output iptc_pkg::op_t data_o
);
  import iptc_pkg::*;

  op_t        entry_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= data_i;
    end
  end

endmodule

FILE: sv/iptc_back.sv
// ----------------------------------------------------------------------------
// iptc_back
// operator stack engine: pops, pushes and emits postfix results
// ----------------------------------------------------------------------------
module iptc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  iptc_pkg::op_t      q_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iptc_pkg::out_item_t out_item_o
);
  import iptc_pkg::*;

  back_state_e state_q, state_d;
  op_t         op_q;
  logic [CNT_W-1:0] count_q, count_d;
  out_item_t   hold_q, hold_d;
  logic        hold_v_q, hold_v_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [CODE_W-1:0] top;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic              empty, full, slot_free, go, load_out;

  // decision of the evaluate state
  logic        new_v, do_pop, do_push, fin;
  out_item_t   new_item;
  logic [1:0]  op_prec;

  iptc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i(op_q.code),
    .raddr_i(raddr),
    .rdata_o(top)
  );

  // always read the current top entry
  assign raddr     = count_q[ADDR_W-1:0] - ADDR_W'(1);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign op_prec   = code_to_prec(op_q.code);

  always_comb begin
    new_v             = 1'b0;
    do_pop            = 1'b0;
    do_push           = 1'b0;
    fin               = 1'b1;
    new_item.out_char = CH_NUL;
    new_item.has_char = 1'b0;
    new_item.last_of_run = 1'b0;
    new_item.status   = ST_OK;
    case (op_q.kind)
      K_END: begin
        if (!empty) begin
          new_v = 1'b1; new_item.out_char = code_to_char(top); new_item.has_char = 1'b1;
          do_pop = 1'b1; fin = 1'b0;
        end else begin
          new_v = 1'b1;
        end
      end
      K_OPERAND: begin
        new_v = 1'b1; new_item.out_char = op_q.ch; new_item.has_char = 1'b1;
      end
      K_OPEN: begin
        if (full) begin
          new_v = 1'b1; new_item.status = ST_OVERFLOW;
        end else begin
          do_push = 1'b1;
        end
      end
      K_CLOSE: begin
        if (empty) begin
          new_v = 1'b1; new_item.status = ST_UNDERFLOW;
        end else if (top != OP_LPAR) begin
          new_v = 1'b1; new_item.out_char = code_to_char(top); new_item.has_char = 1'b1;
          do_pop = 1'b1; fin = 1'b0;
        end else begin
          do_pop = 1'b1;
        end
      end
      K_OPER: begin
        if (!empty && (code_to_prec(top) >= op_prec) &&
            !((op_q.code == OP_POW) && (top == OP_POW))) begin
          new_v = 1'b1; new_item.out_char = code_to_char(top); new_item.has_char = 1'b1;
          do_pop = 1'b1; fin = 1'b0;
        end else if (full) begin
          new_v = 1'b1; new_item.status = ST_OVERFLOW;
        end else begin
          do_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // moving a held result out needs a free output slot
  assign go = !(new_v && hold_v_q) || slot_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = ((q_data_i.kind == K_OPERAND) || (q_data_i.kind == K_OPEN)) ? S_EVAL
                                                                                   : S_FETCH;
        end
      end
      S_FETCH: state_d = S_EVAL;
      S_EVAL: begin
        if (go) begin
          if (!fin) begin
            state_d = S_FETCH;
          end else if (new_v || hold_v_q) begin
            state_d = S_DRAIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop_o  = (state_q == S_IDLE);
    count_d  = count_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    we       = 1'b0;
    load_out = 1'b0;
    out_d    = out_q;
    if ((state_q == S_EVAL) && go) begin
      we = do_push;
      if (do_push) begin
        count_d = count_q + CNT_W'(1);
      end else if (do_pop) begin
        count_d = count_q - CNT_W'(1);
      end
      if (new_v) begin
        if (hold_v_q) begin
          load_out          = 1'b1;
          out_d             = hold_q;
          out_d.last_of_run = 1'b0;
        end
        hold_d   = new_item;
        hold_v_d = 1'b1;
      end
    end else if ((state_q == S_DRAIN) && slot_free) begin
      load_out          = 1'b1;
      out_d             = hold_q;
      out_d.last_of_run = 1'b1;
      hold_v_d          = 1'b0;
    end
    out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && q_valid_i) begin
      op_q <= q_data_i;
    end
    hold_q <= hold_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_drain_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> hold_v_q)
    else $error("drain with nothing held");

  a_char_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.has_char) |-> (out_q.status == ST_OK))
    else $error("character result carries an error status");

  a_pop_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_EVAL))
    else $error("fetch not followed by evaluate");

endmodule

FILE: sv/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting yard converter: infix characters in, postfix characters out
// ----------------------------------------------------------------------------
// request path: an operand's request is popped from the queue into the op
//   register, evaluated into the hold stage, then drained to the output register
// flow: the back takes a new request only when idle; each operator popped
//   needs a fetch and an evaluate step, set by the registered stack read
// reset: asynchronous, active low; clears the stack count, queue and output
//   valid; the stack memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iptc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iptc_pkg::out_item_t out_item_o
);
  import iptc_pkg::*;

  // front to queue
  logic q_push;
  op_t  q_wdata;
  logic q_full;

  // queue to back
  logic q_valid;
  logic q_pop;
  op_t  q_rdata;

  // front: classifies each request, drops characters with no effect
  iptc_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata),
    .q_full_i  (q_full)
  );

  // short queue so that front and back stall independently
  iptc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  // back: operator stack, pop loop and output register
  iptc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_data_i   (q_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
